### hdl/ism_pkg.sv
package ism_pkg;

  localparam int unsigned ROW_W       = 7;
  localparam int unsigned COL_W       = 7;
  localparam int unsigned REQ_W       = 2;
  localparam int unsigned COIN_W      = 5;
  localparam int unsigned RAND_W      = 31;
  localparam int unsigned RAND_INPUTS = 5;
  localparam int unsigned ENERGY_W    = 4;
  localparam int unsigned FLIP_W      = 3;
  localparam int unsigned MAG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 31;

  localparam int unsigned SIDE_DEF      = 128;
  localparam int unsigned HITS_DEF      = 5;
  localparam int unsigned RAND_BITS_DEF = 31;

  localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_E2 = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_E4 = 1'b1;

  localparam logic [RAND_W-1:0] THRESH_RESET = {RAND_W{1'b1}};

endpackage

### hdl/ising_metropolis_multihit_top.sv
// Two-dimensional Ising lattice with periodic wrap and Metropolis multihit updates.
// The input channel (in_valid_i / in_stall_o) carries one request item naming a
// site: write its spin, run up to five coin-gated Metropolis hits on it, or read
// it (an unknown request type acts as a read). Every item gives exactly one result
// item on the output channel (out_valid_o / out_stall_i): the spin, local energy,
// number of accepted flips and the running magnetization after the request.
// The lattice is a row-wide synchronous memory, one row per word. An item reads
// the row above, the site's own row and the row below, one per cycle through the
// single memory port, then computes all hits combinationally in the EXEC state and,
// for a write or an update, writes the row back. The first row read is issued in
// the accepting cycle; the result register is loaded on leaving EXEC, after the RDC
// and RDD states, and no new item is taken until the block is back in IDLE.
// While a result waits on a stalled receiver the next item is still accepted and
// read in; it holds before its write-back until the output register frees up.
// Reset is immediate: a valid flag per row marks rows never written since reset,
// and such rows read as all spins -1. Magnetization resets to -(SIDE*SIDE) and
// both acceptance thresholds to all ones. Thresholds are written through the
// cfg port; write them only while the block is idle; the block does not enforce it.
module ising_metropolis_multihit_top
  import ism_pkg::*;
#(
  parameter int unsigned SIDE      = SIDE_DEF,
  parameter int unsigned HITS      = HITS_DEF,
  parameter int unsigned RAND_BITS = RAND_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [REQ_W-1:0]           req_type_i,
  input  logic [ROW_W-1:0]           row_i,
  input  logic [COL_W-1:0]           col_i,
  input  logic                       spin_in_i,
  input  logic [COIN_W-1:0]          coin_bits_i,
  input  logic [RAND_W-1:0]          rand_hit0_i,
  input  logic [RAND_W-1:0]          rand_hit1_i,
  input  logic [RAND_W-1:0]          rand_hit2_i,
  input  logic [RAND_W-1:0]          rand_hit3_i,
  input  logic [RAND_W-1:0]          rand_hit4_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       spin_out_o,
  output logic signed [ENERGY_W-1:0] local_energy_o,
  output logic [FLIP_W-1:0]          flip_count_o,
  output logic signed [MAG_W-1:0]    magnetization_o
);

  localparam int unsigned IDX_W = $clog2(SIDE);
  localparam int unsigned NHIT  = (HITS < RAND_INPUTS) ? HITS : RAND_INPUTS;
  localparam int unsigned CMP_W = (RAND_BITS < RAND_W) ? RAND_BITS : RAND_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SIDE - 1);
  localparam logic signed [MAG_W-1:0] MAG_RESET = MAG_W'(-(SIDE * SIDE));

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RDC  = 2'd1;
  localparam logic [1:0] ST_RDD  = 2'd2;
  localparam logic [1:0] ST_EXEC = 2'd3;

  function automatic logic [IDX_W-1:0] wrap_idx(input logic [ROW_W-1:0] v);
    logic [ROW_W-1:0] t;
    t = v;
    for (int k = ROW_W - 1; k >= 0; k--) begin
      if (32'(t) >= (SIDE << k)) begin
        t = t - ROW_W'(SIDE << k);
      end
    end
    return IDX_W'(t);
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] v);
    return (v == '0) ? IDX_LAST : v - IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] v);
    return (v == IDX_LAST) ? '0 : v + IDX_W'(1);
  endfunction

  function automatic logic signed [ENERGY_W-1:0] site_energy(input logic s,
                                                             input logic [2:0] cnt);
    logic [ENERGY_W-1:0] cnt2;
    cnt2 = {cnt, 1'b0};
    return s ? $signed(4'd4 - cnt2) : $signed(cnt2 - 4'd4);
  endfunction

  logic [1:0] state_q, state_d;

  logic [RAND_W-1:0] thr_e2_q, thr_e4_q;

  logic [REQ_W-1:0]  req_q;
  logic [IDX_W-1:0]  row_q, col_q;
  logic              spin_q;
  logic [NHIT-1:0]   coin_q;
  logic [RAND_W-1:0] rand_q [NHIT];
  logic [RAND_W-1:0] rand_in [RAND_INPUTS];

  logic [SIDE-1:0]   lat_mem [SIDE];
  logic [SIDE-1:0]   row_vld_q;
  logic [SIDE-1:0]   rd_row_q;
  logic              rd_vld_q;
  logic [SIDE-1:0]   eff_row;
  logic [SIDE-1:0]   ctr_row_q;
  logic              up_bit_q;

  logic              mem_re;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic [SIDE-1:0]   wr_row;

  logic              accept;
  logic              go;
  logic              is_write, is_update;
  logic [2:0]        nbr_cnt;
  logic              spin0;
  logic signed [ENERGY_W-1:0] e0;
  logic [RAND_W-1:0] thr_sel;
  logic [NHIT-1:0]   pass;
  logic [FLIP_W-1:0] flips;
  logic              new_spin;

  logic              out_valid_q;
  logic              spin_out_q;
  logic signed [ENERGY_W-1:0] energy_q;
  logic [FLIP_W-1:0] flips_q;
  logic signed [MAG_W-1:0]    mag_q;

  assign rand_in[0] = rand_hit0_i;
  assign rand_in[1] = rand_hit1_i;
  assign rand_in[2] = rand_hit2_i;
  assign rand_in[3] = rand_hit3_i;
  assign rand_in[4] = rand_hit4_i;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign go         = !out_valid_q || !out_stall_i;
  assign is_write   = (req_q == REQ_WRITE);
  assign is_update  = (req_q == REQ_UPDATE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_RDC;
      ST_RDC:  state_d = ST_RDD;
      ST_RDD:  state_d = ST_EXEC;
      ST_EXEC: if (go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_re  = 1'b0;
    rd_addr = row_q;
    unique case (state_q)
      ST_IDLE: begin
        mem_re  = accept;
        rd_addr = idx_dec(wrap_idx(row_i));
      end
      ST_RDC: begin
        mem_re  = 1'b1;
        rd_addr = row_q;
      end
      ST_RDD: begin
        mem_re  = 1'b1;
        rd_addr = idx_inc(row_q);
      end
      default: begin
        mem_re  = 1'b0;
        rd_addr = row_q;
      end
    endcase
  end

  assign eff_row = rd_vld_q ? rd_row_q : '0;

  always_comb begin
    logic acc;
    logic neg;
    logic zero;
    nbr_cnt = 3'(up_bit_q) + 3'(eff_row[col_q]) + 3'(ctr_row_q[idx_dec(col_q)])
            + 3'(ctr_row_q[idx_inc(col_q)]);
    spin0   = ctr_row_q[col_q];
    e0      = site_energy(spin0, nbr_cnt);
    thr_sel = ((e0 == 4'sd2) || (e0 == -4'sd2)) ? thr_e2_q : thr_e4_q;
    for (int k = 0; k < NHIT; k++) begin
      pass[k] = (rand_q[k][CMP_W-1:0] <= thr_sel[CMP_W-1:0]);
    end
    neg   = e0[ENERGY_W-1];
    zero  = (e0 == '0);
    flips = '0;
    for (int k = 0; k < NHIT; k++) begin
      acc = coin_q[k] && (zero || !neg || pass[k]);
      if (acc) begin
        neg   = zero ? neg : !neg;
        flips = flips + FLIP_W'(1);
      end
    end
    if (is_write) begin
      new_spin = spin_q;
    end else if (is_update) begin
      new_spin = spin0 ^ flips[0];
    end else begin
      new_spin = spin0;
    end
    wr_row        = ctr_row_q;
    wr_row[col_q] = new_spin;
  end

  assign mem_we = (state_q == ST_EXEC) && go && (is_write || is_update);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lat_mem[row_q] <= wr_row;
    end
    if (mem_re) begin
      rd_row_q <= lat_mem[rd_addr];
      rd_vld_q <= row_vld_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_type_i;
      row_q  <= wrap_idx(row_i);
      col_q  <= wrap_idx(col_i);
      spin_q <= spin_in_i;
      coin_q <= coin_bits_i[NHIT-1:0];
      for (int k = 0; k < NHIT; k++) begin
        rand_q[k] <= rand_in[k];
      end
    end
    if (state_q == ST_RDC) begin
      up_bit_q <= eff_row[col_q];
    end
    if (state_q == ST_RDD) begin
      ctr_row_q <= eff_row;
    end
    if ((state_q == ST_EXEC) && go) begin
      spin_out_q <= new_spin;
      energy_q   <= site_energy(new_spin, nbr_cnt);
      flips_q    <= is_update ? flips : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_e2_q    <= THRESH_RESET;
      thr_e4_q    <= THRESH_RESET;
      row_vld_q   <= '0;
      mag_q       <= MAG_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_THRESH_E2: thr_e2_q <= cfg_data_i;
          CFG_THRESH_E4: thr_e4_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (mem_we) begin
        row_vld_q[row_q] <= 1'b1;
      end
      if ((state_q == ST_EXEC) && go) begin
        out_valid_q <= 1'b1;
        if (new_spin != spin0) begin
          mag_q <= new_spin ? mag_q + MAG_W'(2) : mag_q - MAG_W'(2);
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign spin_out_o      = spin_out_q;
  assign local_energy_o  = energy_q;
  assign flip_count_o    = flips_q;
  assign magnetization_o = mag_q;

endmodule

### hdl/ism_chk.sv
module ism_chk
  import ism_pkg::*;
(
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       spin_out_o,
  input logic signed [ENERGY_W-1:0] local_energy_o,
  input logic [FLIP_W-1:0]          flip_count_o,
  input logic signed [MAG_W-1:0]    magnetization_o
);

  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Input was not stalled after an item was taken.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(spin_out_o)
      && $stable(local_energy_o) && $stable(flip_count_o))
    else $error("Stalled result changed or was dropped.");

  a_energy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !local_energy_o[0] && (local_energy_o != -4'sd6)
      && (local_energy_o != -4'sd8) && (local_energy_o != 4'sd6))
    else $error("Local energy is not one of -4, -2, 0, 2, 4.");

  a_flip_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (flip_count_o <= FLIP_W'(RAND_INPUTS)))
    else $error("Flip count exceeds the number of hits.");

  a_mag_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (magnetization_o != $past(magnetization_o)) |->
      (MAG_W'(magnetization_o - $past(magnetization_o)) == MAG_W'(2))
      || (MAG_W'($past(magnetization_o) - magnetization_o) == MAG_W'(2)))
    else $error("Magnetization moved by other than one spin flip.");

endmodule

bind ising_metropolis_multihit_top ism_chk u_ism_chk (.*);
